// ===== rtl/scd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the scancode decoder: key codes, decode result type and character table.
// No dependencies; imported by scd_decode, scancode_to_ascii_decoder_top and scd_checker.
package scd_pkg;

  localparam int CodeW = 8;
  localparam int CharW = 7;
  localparam int DataW = 8;

  localparam logic [CodeW-1:0] CODE_LAST      = 8'd59;
  localparam logic [CodeW-1:0] LSHIFT_PRESS   = 8'd42;
  localparam logic [CodeW-1:0] RSHIFT_PRESS   = 8'd54;
  localparam logic [CodeW-1:0] CAPS_PRESS     = 8'd58;
  localparam logic [CodeW-1:0] LSHIFT_RELEASE = 8'd170;
  localparam logic [CodeW-1:0] RSHIFT_RELEASE = 8'd182;

  typedef struct packed {
    logic             emit;
    logic [CharW-1:0] character;
    logic             shift_held;
    logic             caps_on;
  } dec_result_t;

  function automatic logic is_letter(input logic [5:0] code);
    return code inside {[6'd16:6'd25], [6'd30:6'd38], [6'd44:6'd50]};
  endfunction

  // Two-column key table: {plain, shifted}.
  function automatic logic [2*CharW-1:0] char_pair(input logic [5:0] code);
    logic [2*CharW-1:0] p;
    case (code)
      6'd1:  p = {7'h7E, 7'h7E};
      6'd2:  p = {7'h31, 7'h21};
      6'd3:  p = {7'h32, 7'h40};
      6'd4:  p = {7'h33, 7'h23};
      6'd5:  p = {7'h34, 7'h24};
      6'd6:  p = {7'h35, 7'h25};
      6'd7:  p = {7'h36, 7'h5E};
      6'd8:  p = {7'h37, 7'h26};
      6'd9:  p = {7'h38, 7'h2A};
      6'd10: p = {7'h39, 7'h28};
      6'd11: p = {7'h30, 7'h29};
      6'd12: p = {7'h2D, 7'h5F};
      6'd13: p = {7'h3D, 7'h2B};
      6'd14: p = {7'h08, 7'h08};
      6'd15: p = {7'h09, 7'h09};
      6'd16: p = {7'h71, 7'h51};
      6'd17: p = {7'h77, 7'h57};
      6'd18: p = {7'h65, 7'h45};
      6'd19: p = {7'h72, 7'h52};
      6'd20: p = {7'h74, 7'h54};
      6'd21: p = {7'h79, 7'h59};
      6'd22: p = {7'h75, 7'h55};
      6'd23: p = {7'h69, 7'h49};
      6'd24: p = {7'h6F, 7'h4F};
      6'd25: p = {7'h70, 7'h50};
      6'd26: p = {7'h5B, 7'h7B};
      6'd27: p = {7'h5D, 7'h7D};
      6'd28: p = {7'h0A, 7'h0A};
      6'd30: p = {7'h61, 7'h41};
      6'd31: p = {7'h73, 7'h53};
      6'd32: p = {7'h64, 7'h44};
      6'd33: p = {7'h66, 7'h46};
      6'd34: p = {7'h67, 7'h47};
      6'd35: p = {7'h68, 7'h48};
      6'd36: p = {7'h6A, 7'h4A};
      6'd37: p = {7'h6B, 7'h4B};
      6'd38: p = {7'h6C, 7'h4C};
      6'd39: p = {7'h3B, 7'h3A};
      6'd40: p = {7'h27, 7'h22};
      6'd41: p = {7'h60, 7'h7E};
      6'd43: p = {7'h5C, 7'h7C};
      6'd44: p = {7'h7A, 7'h5A};
      6'd45: p = {7'h78, 7'h58};
      6'd46: p = {7'h63, 7'h43};
      6'd47: p = {7'h76, 7'h56};
      6'd48: p = {7'h62, 7'h42};
      6'd49: p = {7'h6E, 7'h4E};
      6'd50: p = {7'h6D, 7'h4D};
      6'd51: p = {7'h2C, 7'h3C};
      6'd52: p = {7'h2E, 7'h3E};
      6'd53: p = {7'h2F, 7'h3F};
      6'd55: p = {7'h2A, 7'h2A};
      6'd57: p = {7'h20, 7'h20};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/scd_decode.sv =====
`timescale 1ns / 1ps
// Combinational decode of one scancode against the current shift and caps flags.
// Depends on scd_pkg for key codes, the character table and dec_result_t.
module scd_decode (
  input  logic [scd_pkg::CodeW-1:0] code,
  input  logic                      shift_held,
  input  logic                      caps_on,
  output scd_pkg::dec_result_t      result
);
  import scd_pkg::*;

  logic [2*CharW-1:0] pair;
  logic               upper;
  logic               in_range;

  assign pair     = char_pair(code[5:0]);
  assign in_range = (code != '0) && (code <= CODE_LAST);
  assign upper    = is_letter(code[5:0]) ? (caps_on | shift_held) : shift_held;

  always_comb begin
    result.emit       = 1'b0;
    result.character  = upper ? pair[CharW-1:0] : pair[2*CharW-1:CharW];
    result.shift_held = shift_held;
    result.caps_on    = caps_on;
    if (code == LSHIFT_RELEASE || code == RSHIFT_RELEASE) begin
      result.shift_held = 1'b0;
    end else if (in_range) begin
      if (code == LSHIFT_PRESS || code == RSHIFT_PRESS) begin
        result.shift_held = 1'b1;
      end else if (code == CAPS_PRESS) begin
        result.caps_on = ~caps_on;
      end else begin
        result.emit = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/scancode_to_ascii_decoder_top.sv =====
`timescale 1ns / 1ps
// Set-1 scancode to ASCII decoder: input register, decode, output register.
// Depends on scd_pkg and scd_decode.
// A character beat passes the input register and then the output register before m_tvalid rises.
// Throughput: one scancode beat per cycle, set by the single decode stage, while the output slot is free or draining.
// Reset (rst, synchronous): clears shift and caps flags and both valid flags.
module scancode_to_ascii_decoder_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [scd_pkg::DataW-1:0] s_tdata,   // [7:0] scan_code
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [scd_pkg::DataW-1:0] m_tdata    // [6:0] character, [7] zero
);
  import scd_pkg::*;

  // Input register
  logic             in_valid;
  logic [CodeW-1:0] in_code;

  // Keyboard modifier state
  logic shift_held;
  logic caps_on;

  // Output register
  logic             out_valid;
  logic [CharW-1:0] out_char;

  dec_result_t dec;
  logic        out_free;
  logic        advance;

  scd_decode u_decode (
    .code       (in_code),
    .shift_held (shift_held),
    .caps_on    (caps_on),
    .result     (dec)
  );

  // Output slot can take a new character when empty or being drained this cycle.
  assign out_free = ~out_valid | m_tready;
  // Retire the held beat: beats with no character never wait on the output side.
  assign advance  = in_valid & (~dec.emit | out_free);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Capture a new scancode beat, or drop the slot once it has retired.
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      // Flags advance in beat order, only when the beat retires.
      if (advance) begin
        shift_held <= dec.shift_held;
        caps_on    <= dec.caps_on;
      end
      // Drain the output, then refill it if a character retires.
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (advance && dec.emit) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code <= s_tdata[CodeW-1:0];
    end
    if (advance && dec.emit) begin
      out_char <= dec.character;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(DataW-CharW){1'b0}}, out_char};

endmodule

// ===== rtl/scd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the scancode decoder, bound to the top level.
// Depends on scd_pkg for widths.
module scd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [scd_pkg::DataW-1:0] s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [scd_pkg::DataW-1:0] m_tdata
);
  import scd_pkg::*;

  // Hold a stalled character beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // Characters are 7-bit ASCII.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[DataW-1:CharW] == '0)
    else $error("output padding bits not zero");

  // Reset empties both sides.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not empty after reset");

  // An empty output slot never stalls the input.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with output empty");

endmodule

bind scancode_to_ascii_decoder_top scd_checker u_scd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
